>>> rtl/idshv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package idshv_pkg;

  // Hash and check constants
  localparam logic [31:0] MAGIC_WORD = 32'h4E45_5854;
  localparam logic [31:0] HASH_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;
  localparam logic [31:0] MIX_XOR    = 32'h5A5A_A5A5;
  localparam logic [31:0] MIX_ADD    = 32'h9E37_79B9;
  localparam logic [7:0]  CHAR_LOW   = 8'h61;
  localparam logic [7:0]  CHAR_HIGH  = 8'h70;
  localparam int unsigned COUNT_W    = 7;

  // Input item as held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] id_byte;
    logic       last;
  } stage_t;

  // One verification result
  typedef struct packed {
    logic        pass;
    logic [31:0] token;
  } result_t;

  // Fold one byte into the running hash
  function automatic logic [31:0] fold_byte(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    logic [31:0] p;
    logic [31:0] r;
    x = h ^ {24'd0, b};
    p = x * HASH_PRIME;
    r = {p[18:0], p[31:19]};
    return (r ^ MIX_XOR) + MIX_ADD;
  endfunction

endpackage
`default_nettype wire

>>> rtl/idshv_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface idshv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] id_byte;
  logic       last;

  modport source (output valid, output id_byte, output last, input ready);
  modport sink   (input valid, input id_byte, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/idshv_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface idshv_out_if;
  logic        valid;
  logic        ready;
  logic        pass;
  logic [31:0] token;

  modport source (output valid, output pass, output token, input ready);
  modport sink   (input valid, input pass, input token, output ready);
endinterface
`default_nettype wire

>>> rtl/idshv_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface idshv_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/idshv_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module idshv_in_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [7:0]       in_id_byte,
  input  wire logic             in_last,
  input  wire logic             take,
  output logic                  in_ready,
  output idshv_pkg::stage_t     stage
);
  import idshv_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load;

  // Accept when the register is empty or drains this cycle
  assign in_ready  = !valid_r || take;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the payload on each input transfer
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_id_byte;
      last_r <= in_last;
    end
  end

  assign stage.valid   = valid_r;
  assign stage.id_byte = byte_r;
  assign stage.last    = last_r;
endmodule
`default_nettype wire

>>> rtl/idshv_fold.sv
`timescale 1ns / 1ps
`default_nettype none
module idshv_fold #(
  parameter int unsigned ID_LENGTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire idshv_pkg::stage_t stage,
  input  wire logic              take,
  input  wire logic              dev_mode,
  output idshv_pkg::result_t     result
);
  import idshv_pkg::*;

  localparam logic [COUNT_W-1:0] LEN_CNT = COUNT_W'(ID_LENGTH);
  localparam logic [COUNT_W-1:0] SAT_CNT = COUNT_W'(ID_LENGTH + 1);

  logic [31:0]        hash_r;
  logic [31:0]        hash_nxt;
  logic [COUNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0] cnt_nxt;
  logic               bad_r;
  logic               bad_nxt;
  logic [31:0]        hash_fold;
  logic [COUNT_W-1:0] cnt_step;
  logic               bad_step;
  logic               ok;

  // Fold the held byte into the running state
  always_comb begin
    hash_fold = fold_byte(hash_r, stage.id_byte);
    cnt_step  = (cnt_r < SAT_CNT) ? cnt_r + COUNT_W'(1) : cnt_r;
    bad_step  = bad_r || (stage.id_byte < CHAR_LOW) || (stage.id_byte > CHAR_HIGH);
    ok        = dev_mode || ((cnt_step == LEN_CNT) && !bad_step);

    hash_nxt = hash_r;
    cnt_nxt  = cnt_r;
    bad_nxt  = bad_r;
    if (take) begin
      if (stage.last) begin
        hash_nxt = HASH_BASIS;
        cnt_nxt  = '0;
        bad_nxt  = 1'b0;
      end else begin
        hash_nxt = hash_fold;
        cnt_nxt  = cnt_step;
        bad_nxt  = bad_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= HASH_BASIS;
      cnt_r  <= '0;
      bad_r  <= 1'b0;
    end else begin
      hash_r <= hash_nxt;
      cnt_r  <= cnt_nxt;
      bad_r  <= bad_nxt;
    end
  end

  // Mask the token on a rejected identifier
  assign result.pass  = ok;
  assign result.token = ok ? (hash_fold ^ MAGIC_WORD) : 32'd0;
endmodule
`default_nettype wire

>>> rtl/idshv_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
module idshv_out_reg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire idshv_pkg::result_t result,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic                    free,
  output idshv_pkg::result_t      out_data
);
  import idshv_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t data_r;

  // Slot is free when empty or when its result transfers this cycle
  assign free      = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
endmodule
`default_nettype wire

>>> rtl/id_string_hash_verifier_core.sv
// Identifier hash verifier.
// in_ch carries one identifier byte per transfer (id_byte, last). Every byte
// is folded into a running 32-bit hash; the byte with last=1 closes the
// identifier and produces one transfer on out_ch (pass, token). Bytes with
// last=0 produce no result.
// cfg_ch writes the dev_mode bit (always ready); write it only while idle.
// out_ch.valid rises once the last byte has passed the input register and
// been folded into the result register, which loads as the byte is taken.
// Throughput: one byte per cycle while no last byte waits for a busy result
// slot, set by the combinational fold of the hash register (one constant
// multiply, rotate, xor and add).
// A stall on out_ch holds the result; non-last bytes keep flowing until a
// new last byte reaches the fold stage, which then waits for the slot.
// Reset (rst_n low, synchronous) empties both registers, sets the hash to
// the offset basis, clears the count and bad-byte flag and clears dev_mode.
`timescale 1ns / 1ps
`default_nettype none
module id_string_hash_verifier_core #(
  parameter int unsigned ID_LENGTH = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  idshv_in_if.sink    in_ch,
  idshv_out_if.source out_ch,
  idshv_cfg_if.sink   cfg_ch
);
  import idshv_pkg::*;

  stage_t  stage;
  result_t result;
  result_t out_data;
  logic    take;
  logic    out_free;
  logic    dev_mode_r;

  // Configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_mode_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      dev_mode_r <= cfg_ch.data;
    end
  end

  // Advance the held byte unless it closes an identifier and the slot is busy
  assign take = stage.valid && (!stage.last || out_free);

  idshv_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_id_byte (in_ch.id_byte),
    .in_last    (in_ch.last),
    .take       (take),
    .in_ready   (in_ch.ready),
    .stage      (stage)
  );

  idshv_fold #(
    .ID_LENGTH (ID_LENGTH)
  ) u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (stage),
    .take     (take),
    .dev_mode (dev_mode_r),
    .result   (result)
  );

  idshv_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && stage.last),
    .result    (result),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .free      (out_free),
    .out_data  (out_data)
  );

  assign out_ch.pass  = out_data.pass;
  assign out_ch.token = out_data.token;
endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import idshv_pkg::*;

  localparam int unsigned ID_LEN = 32;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef enum {ID_CLEAN, ID_ANY, ID_ONE_BAD} id_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  idshv_in_if  in_ch ();
  idshv_out_if out_ch ();
  idshv_cfg_if cfg_ch ();

  id_string_hash_verifier_core #(.ID_LENGTH(ID_LEN)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: one identifier in flight plus the dev_mode register
  logic [31:0] id_hash;
  logic [6:0]  id_count;
  logic        id_bad;
  logic        dev_mode_q;

  result_t verdict_q[$];

  bit idle_enable;
  int mismatches;
  int bytes_sent;
  int ids_sent;
  int accepted_seen;
  int rejected_seen;
  int idle_cycles;

  always #5 clk = ~clk;

  // Fold one byte: FNV-1a xor/multiply, rotate left 13, xor, add
  function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] mixed;
    logic [31:0] prod;
    mixed = h ^ {24'd0, b};
    prod  = mixed * HASH_PRIME;
    return ({prod[18:0], prod[31:19]} ^ MIX_XOR) + MIX_ADD;
  endfunction

  task automatic clear_identifier();
    id_hash  = HASH_BASIS;
    id_count = '0;
    id_bad   = 1'b0;
  endtask

  // Advance the predictor by one accepted byte; queue a verdict on the last one
  task automatic predict_verdict(input logic [7:0] b, input logic is_last);
    result_t v;
    id_hash = hash_step(id_hash, b);
    if (id_count < ID_LEN + 1) id_count = id_count + 1'b1;
    if (b < CHAR_LOW || b > CHAR_HIGH) id_bad = 1'b1;
    if (is_last) begin
      if (dev_mode_q || (id_count == ID_LEN && !id_bad)) begin
        v.pass  = 1'b1;
        v.token = id_hash ^ MAGIC_WORD;
      end else begin
        v.pass  = 1'b0;
        v.token = '0;
      end
      verdict_q.push_back(v);
      clear_identifier();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Send one byte; optionally hold off with a random burst of idle cycles
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    @(negedge clk);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.id_byte <= b;
    in_ch.last    <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    predict_verdict(b, is_last);
    bytes_sent++;
    if (is_last) ids_sent++;
  endtask

  function automatic logic [7:0] pick_bad_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h60;
      1:       return 8'h71;
      2:       return 8'($urandom_range(0, 8'h60));
      default: return 8'($urandom_range(8'h71, 8'hFF));
    endcase
  endfunction

  // Send a whole identifier of the given length and content kind
  task automatic send_id(input int len, input id_kind_t kind);
    int bad_pos;
    logic [7:0] b;
    bad_pos = $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) begin
      if (kind == ID_ANY) b = 8'($urandom_range(0, 255));
      else if (kind == ID_ONE_BAD && i == bad_pos) b = pick_bad_byte();
      else b = 8'($urandom_range(CHAR_LOW, CHAR_HIGH));
      send_byte(b, i == len - 1);
    end
  endtask

  // Drop valid and let the pipeline drain before touching the register
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_dev_mode(input logic v);
    wait_idle();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    dev_mode_q = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Checker: compare each result transfer with the oldest predicted verdict
  always @(posedge clk) begin
    result_t exp_v;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result pass=%0b token=%08h",
                                  out_ch.pass, out_ch.token));
      end else begin
        exp_v = verdict_q.pop_front();
        if (out_ch.pass !== exp_v.pass)
          report_mismatch($sformatf("pass got %0b exp %0b", out_ch.pass, exp_v.pass));
        if (out_ch.token !== exp_v.token)
          report_mismatch($sformatf("token got %08h exp %08h", out_ch.token, exp_v.token));
        if (exp_v.pass) accepted_seen++;
        else rejected_seen++;
      end
    end
  end

  // Result-side backpressure in random bursts
  always @(negedge clk) begin
    static int stall_left = 0;
    if (!idle_enable) begin
      stall_left = 0;
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Two correct identifiers from reset, the first with both edge characters
  task automatic test_clean_identifier();
    for (int i = 0; i < ID_LEN; i++)
      send_byte((i % 2 == 0) ? CHAR_LOW : CHAR_HIGH, i == ID_LEN - 1);
    send_id(ID_LEN, ID_CLEAN);
  endtask

  // Too short, too long (count saturates), one byte
  task automatic test_length_errors();
    send_id(ID_LEN - 1, ID_CLEAN);
    send_id(ID_LEN + 1, ID_CLEAN);
    send_id(ID_LEN + 40, ID_CLEAN);
    send_id(1, ID_CLEAN);
  endtask

  // Right length with a character just outside the range
  task automatic test_bad_bytes();
    for (int i = 0; i < ID_LEN; i++) send_byte((i == 0) ? 8'h60 : CHAR_LOW, i == ID_LEN - 1);
    for (int i = 0; i < ID_LEN; i++) send_byte((i == 5) ? 8'h71 : CHAR_HIGH, i == ID_LEN - 1);
  endtask

  // Extreme byte values as one-byte identifiers, then a two-byte identifier
  task automatic test_field_extremes();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
  endtask

  // Development mode lets any identifier through, then back to checking
  task automatic test_dev_mode();
    write_dev_mode(1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_id(ID_LEN, ID_ONE_BAD);
    send_id(ID_LEN + 3, ID_ANY);
    write_dev_mode(1'b0);
    send_byte(8'hFF, 1'b1);
    send_id(ID_LEN, ID_CLEAN);
  endtask

  // Mostly well-formed identifiers with random content, plus broken ones
  task automatic test_random_traffic(input int n_bytes);
    int start;
    int pick;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      send_id(ID_LEN, ID_CLEAN);
      else if (pick < 70) send_id(ID_LEN, ID_ONE_BAD);
      else if (pick < 80) send_id($urandom_range(0, 1) ? ID_LEN - 1 : ID_LEN + 1, ID_CLEAN);
      else if (pick < 95) send_id($urandom_range(1, 40), ID_ANY);
      else                send_id($urandom_range(ID_LEN + 2, 90), ID_CLEAN);
    end
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.id_byte = '0;
    in_ch.last    = 1'b0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = 1'b0;
    idle_enable   = 1'b1;
    idle_cycles   = 0;
    dev_mode_q    = 1'b0;
    clear_identifier();

    // Hold reset, release at a falling edge
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_clean_identifier();
    test_length_errors();
    test_bad_bytes();
    test_field_extremes();
    test_dev_mode();

    test_random_traffic(560);
    write_dev_mode(1'b1);
    test_random_traffic(400);
    write_dev_mode(1'b0);
    wait_idle();
    idle_enable = 1'b0;
    test_random_traffic(420);

    // Drain and close out
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));

    $display("Sent %0d bytes in %0d identifiers, dev_mode toggled both ways",
             bytes_sent, ids_sent);
    $display("Results checked: %0d accepted, %0d rejected, %0d mismatches",
             accepted_seen, rejected_seen, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
